FILE: rtl/lcs_eng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_eng_pkg
// Shared types and constants of the LCS length engine: request codes,
// sizes of the X store and the row store, beat structs and FSM states.
// ----------------------------------------------------------------------------
package lcs_eng_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 7;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_PROCESS = 2'd2,
    REQ_FINISH  = 2'd3
  } req_t;

  typedef struct packed {
    req_t             req_type;
    logic [SYM_W-1:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] lcs_length;
    logic             truncated;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/lcs_length_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_length_engine_unit
// Longest common subsequence length of a stored byte string X and a
// streamed byte string Y, with the dynamic-programming row in block RAM.
// ----------------------------------------------------------------------------
// Usage: send a clear beat to start a pair, append beats to load X (up to
// MAX_LEN bytes, extra bytes are dropped and flagged), process beats to
// stream Y, and a finish beat to get one result beat on the out channel.
// Clear and append beats are handled without leaving the idle state. A
// process beat scans the stored X: one row entry is read, updated and
// written back per cycle, bounded by the single read and write port of the
// row RAM, and the next item waits for the scan to end. A finish beat reads
// the last row entry from the RAM, then loads the output register with its
// result once that register is free.
// A waiting result does not block clear, append or process beats; a second
// finish waits until the first result is taken. Stalls on out_ready
// hold the output register and a finish that waits for it.
// Reset empties X, drops the overflow flag and idles the FSM. The RAMs are
// not swept: append zeroes each row entry as it stores its X byte, and only
// entries below the fill count are read.
// ----------------------------------------------------------------------------
module lcs_length_engine_unit (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire lcs_eng_pkg::in_beat_t  in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output lcs_eng_pkg::out_beat_t      out_data
);

  localparam int MAX_LEN = lcs_eng_pkg::MAX_LEN;
  localparam int IDX_W   = lcs_eng_pkg::IDX_W;
  localparam int CNT_W   = lcs_eng_pkg::CNT_W;
  localparam int SYM_W   = lcs_eng_pkg::SYM_W;
  localparam int LEN_W   = lcs_eng_pkg::LEN_W;

  // storage
  logic [SYM_W-1:0] x_mem  [MAX_LEN];
  logic [CNT_W-1:0] dp_mem [MAX_LEN];
  logic [SYM_W-1:0] x_rdata_r;
  logic [CNT_W-1:0] dp_rdata_r;

  // control state
  lcs_eng_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             p1_r, p1_nxt;

  // datapath state
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] wa_r, wa_nxt;
  logic [CNT_W-1:0] diag_r, diag_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [SYM_W-1:0] y_r, y_nxt;
  logic             empty_r, empty_nxt;
  lcs_eng_pkg::out_beat_t out_data_r, out_data_nxt;

  // memory ports
  logic             x_we, x_re, dp_we, dp_re;
  logic [IDX_W-1:0] x_wa, dp_wa, dp_ra;
  logic [SYM_W-1:0] x_wd;
  logic [CNT_W-1:0] dp_wd;
  logic [CNT_W-1:0] cell_val;

  logic accept;

  assign in_ready  = (state_r == lcs_eng_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // row update for the entry whose data came back this cycle
  always_comb begin
    if (x_rdata_r == y_r) begin
      cell_val = diag_r + 1'b1;
    end else if (dp_rdata_r >= left_r) begin
      cell_val = dp_rdata_r;
    end else begin
      cell_val = left_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    p1_nxt        = 1'b0;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    y_nxt         = y_r;
    empty_nxt     = empty_r;
    out_data_nxt  = out_data_r;
    x_we          = 1'b0;
    x_re          = 1'b0;
    dp_we         = 1'b0;
    dp_re         = 1'b0;
    x_wa          = cnt_r[IDX_W-1:0];
    x_wd          = in_data.symbol;
    dp_wa         = cnt_r[IDX_W-1:0];
    dp_wd         = '0;
    dp_ra         = idx_r[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lcs_eng_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            lcs_eng_pkg::REQ_CLEAR: begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            lcs_eng_pkg::REQ_APPEND: begin
              if (cnt_r < CNT_W'(MAX_LEN)) begin
                x_we    = 1'b1;
                dp_we   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lcs_eng_pkg::REQ_PROCESS: begin
              y_nxt     = in_data.symbol;
              idx_nxt   = '0;
              diag_nxt  = '0;
              left_nxt  = '0;
              state_nxt = lcs_eng_pkg::ST_SCAN;
            end
            lcs_eng_pkg::REQ_FINISH: begin
              empty_nxt = (cnt_r == '0);
              dp_re     = (cnt_r != '0);
              dp_ra     = IDX_W'(cnt_r - 1'b1);
              state_nxt = lcs_eng_pkg::ST_FIN;
            end
            default: begin
            end
          endcase
        end
      end

      lcs_eng_pkg::ST_SCAN: begin
        // issue the read of entry idx while entry idx-1 is written back
        if (idx_r < cnt_r) begin
          x_re    = 1'b1;
          dp_re   = 1'b1;
          p1_nxt  = 1'b1;
          wa_nxt  = idx_r[IDX_W-1:0];
          idx_nxt = idx_r + 1'b1;
        end
        if (p1_r) begin
          dp_we    = 1'b1;
          dp_wa    = wa_r;
          dp_wd    = cell_val;
          diag_nxt = dp_rdata_r;
          left_nxt = cell_val;
        end
        if (!(idx_r < cnt_r) && !p1_r) begin
          state_nxt = lcs_eng_pkg::ST_IDLE;
        end
      end

      lcs_eng_pkg::ST_FIN: begin
        // hold the read data until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.lcs_length = empty_r ? '0 : LEN_W'(dp_rdata_r);
          out_data_nxt.truncated  = ovf_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = lcs_eng_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lcs_eng_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcs_eng_pkg::ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      p1_r        <= p1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wa_r       <= wa_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    y_r        <= y_nxt;
    empty_r    <= empty_nxt;
    out_data_r <= out_data_nxt;
  end

  // X store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_wa] <= x_wd;
    end
    if (x_re) begin
      x_rdata_r <= x_mem[idx_r[IDX_W-1:0]];
    end
  end

  // row store: read and write never hit the same entry in one cycle
  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_wa] <= dp_wd;
    end
    if (dp_re) begin
      dp_rdata_r <= dp_mem[dp_ra];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("fill count beyond store depth");

  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcs_eng_pkg::ST_SCAN && p1_r) |-> ({1'b0, wa_r} < cnt_r))
    else $error("row write-back outside stored X");

  a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(accept && in_data.req_type == lcs_eng_pkg::REQ_APPEND
                           && cnt_r == CNT_W'(MAX_LEN)))
    else $error("overflow flag set without a dropped append");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lcs_eng_pkg::ST_FIN))
    else $error("result raised outside finish");
`endif

endmodule
`default_nettype wire
